// ===== sv/oal_pkg.sv =====
// Shared types, constants and codes for the ordered array list.
package oal_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_FIND   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] val;
  } cell_cmd_t;

endpackage

// ===== sv/oal_cell.sv =====
// One storage cell of the list row, shifting with its neighbors on insert and delete.
module oal_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [oal_pkg::CNT_W-1:0]        idx_i,
  input  oal_pkg::cell_cmd_t               cmd_i,
  input  logic [oal_pkg::VAL_W-1:0]        left_i,
  input  logic [oal_pkg::VAL_W-1:0]        right_i,
  output logic [oal_pkg::VAL_W-1:0]        entry_o,
  output logic                             match_o
);

  logic [oal_pkg::VAL_W-1:0] entry_q;
  logic [oal_pkg::VAL_W-1:0] entry_d;
  logic [oal_pkg::CNT_W:0]   idx_p1;

  assign idx_p1 = {1'b0, idx_i} + {{oal_pkg::CNT_W{1'b0}}, 1'b1};

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (idx_i == cmd_i.pos) begin
        entry_d = cmd_i.val;
      end else if (idx_i > cmd_i.pos && idx_i <= cmd_i.cnt) begin
        entry_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (idx_p1 == {1'b0, cmd_i.cnt}) begin
        entry_d = '0;
      end else if (idx_i >= cmd_i.pos && idx_p1 < {1'b0, cmd_i.cnt}) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == cmd_i.val) && (idx_i < cmd_i.cnt);

endmodule

// ===== sv/oal_ctrl.sv =====
// Request decode, status, length update, read selection and find encoding.
module oal_ctrl (
  input  logic                                          accept_i,
  input  logic [1:0]                                    req_type_i,
  input  logic [4:0]                                    position_i,
  input  logic [oal_pkg::VAL_W-1:0]                     item_value_i,
  input  logic [oal_pkg::CNT_W-1:0]                     count_i,
  input  logic [4:0]                                    capacity_i,
  input  logic [oal_pkg::DEPTH-1:0][oal_pkg::VAL_W-1:0] entries_i,
  input  logic [oal_pkg::DEPTH-1:0]                     match_i,
  output oal_pkg::cell_cmd_t                            cmd_o,
  output logic [oal_pkg::CNT_W-1:0]                     count_d_o,
  output oal_pkg::status_e                              status_o,
  output logic [oal_pkg::VAL_W-1:0]                     read_value_o,
  output logic [3:0]                                    found_position_o
);

  logic [oal_pkg::CMP_W-1:0] pos_w;
  logic [oal_pkg::CMP_W-1:0] cnt_w;
  logic [oal_pkg::CMP_W-1:0] cap_w;
  logic [oal_pkg::CMP_W-1:0] eff_cap;
  logic [oal_pkg::IDX_W-1:0] hit_idx;
  logic                      hit;
  logic                      do_ins;
  logic                      do_del;

  assign pos_w   = oal_pkg::CMP_W'(position_i);
  assign cnt_w   = oal_pkg::CMP_W'(count_i);
  assign cap_w   = oal_pkg::CMP_W'(capacity_i);
  assign eff_cap = (cap_w > oal_pkg::CMP_W'(oal_pkg::DEPTH)) ?
                   oal_pkg::CMP_W'(oal_pkg::DEPTH) : cap_w;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = oal_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        hit     = 1'b1;
        hit_idx = oal_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_o         = oal_pkg::ST_OK;
    read_value_o     = '0;
    found_position_o = '0;
    do_ins           = 1'b0;
    do_del           = 1'b0;
    count_d_o        = count_i;
    case (oal_pkg::req_e'(req_type_i))
      oal_pkg::REQ_INSERT: begin
        if (pos_w > cnt_w) begin
          status_o = oal_pkg::ST_BADPOS;
        end else if (cnt_w >= eff_cap) begin
          status_o = oal_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_d_o = count_i + oal_pkg::CNT_W'(1);
        end
      end
      oal_pkg::REQ_DELETE: begin
        if (cnt_w == '0) begin
          status_o = oal_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_o = oal_pkg::ST_BADPOS;
        end else begin
          do_del    = 1'b1;
          count_d_o = count_i - oal_pkg::CNT_W'(1);
        end
      end
      oal_pkg::REQ_READ: begin
        if (pos_w >= cnt_w) begin
          status_o = oal_pkg::ST_BADPOS;
        end else begin
          read_value_o = entries_i[oal_pkg::IDX_W'(position_i)];
        end
      end
      oal_pkg::REQ_FIND: begin
        if (hit) begin
          found_position_o = 4'(hit_idx);
        end else begin
          status_o = oal_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        status_o = oal_pkg::ST_OK;
      end
    endcase
  end

  assign cmd_o.ins = do_ins && accept_i;
  assign cmd_o.del = do_del && accept_i;
  assign cmd_o.pos = oal_pkg::CNT_W'(position_i);
  assign cmd_o.cnt = count_i;
  assign cmd_o.val = item_value_i;

endmodule

// ===== sv/ordered_array_list_top.sv =====
// Top level of the ordered array list: cell row, length register and result register.
// The list is held in a row of sixteen cells, one entry each. Every request
// (insert, delete, read or find) completes in the cycle of its transfer: the
// cells shift toward or away from their neighbors, a read selects one cell,
// and a find compares all cells at once and takes the lowest match.
// The result is registered, so it appears in the cycle after the request, and a
// new request is taken in every cycle unless a finished result is still
// waiting to be taken. The capacity register is written through its own
// channel, which is always ready.
module ordered_array_list_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] read_value_o,
  output logic [3:0]         found_position_o,
  output logic [4:0]         list_length_o
);

  logic                                          accept;
  logic [4:0]                                    cap_q;
  logic [oal_pkg::CNT_W-1:0]                     count_q;
  logic [oal_pkg::CNT_W-1:0]                     count_d;
  oal_pkg::cell_cmd_t                            cmd;
  logic [oal_pkg::DEPTH-1:0][oal_pkg::VAL_W-1:0] entries;
  logic [oal_pkg::DEPTH-1:0]                     match;
  oal_pkg::status_e                              status_d;
  logic [oal_pkg::VAL_W-1:0]                     read_d;
  logic [3:0]                                    found_d;
  logic                                          out_valid_q;
  logic [2:0]                                    status_q;
  logic [31:0]                                   read_q;
  logic [3:0]                                    found_q;
  logic [4:0]                                    length_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  oal_ctrl u_ctrl (
    .accept_i         (accept),
    .req_type_i       (req_type_i),
    .position_i       (position_i),
    .item_value_i     (item_value_i),
    .count_i          (count_q),
    .capacity_i       (cap_q),
    .entries_i        (entries),
    .match_i          (match),
    .cmd_o            (cmd),
    .count_d_o        (count_d),
    .status_o         (status_d),
    .read_value_o     (read_d),
    .found_position_o (found_d)
  );

  for (genvar g = 0; g < oal_pkg::DEPTH; g++) begin : g_cell
    logic [oal_pkg::VAL_W-1:0] left;
    logic [oal_pkg::VAL_W-1:0] right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entries[g-1];
    end

    if (g == oal_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entries[g+1];
    end

    oal_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (oal_pkg::CNT_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[g]),
      .match_o (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= 5'(oal_pkg::DEPTH);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      read_q   <= read_d;
      found_q  <= found_d;
      length_q <= 5'(count_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign read_value_o     = read_q;
  assign found_position_o = found_q;
  assign list_length_o    = length_q;

endmodule
